FILE: design/median_filter_wrap_border_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the median filter block
// Shared implication forms; the port checker uses the next-cycle form.
// ---------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_WRAP_BORDER_ASSERT_SVH
`define MEDIAN_FILTER_WRAP_BORDER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MFWB_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define MFWB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: design/mfwb_pkg.sv
// ---------------------------------------------------------------------------
// mfwb_pkg
// Types and constants shared by the median filter block.
// ---------------------------------------------------------------------------
package mfwb_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int COORD_W    = 8;
	localparam int SIZE_W     = 9;
	localparam int CHAN_W     = 8;
	localparam int NCHAN      = 3;
	localparam int PIX_W      = NCHAN * CHAN_W;
	localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int REG_IDX_W  = 1;

	localparam logic [SIZE_W-1:0] MIN_SIZE   = 9'd5;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

	// request command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD,
		ST_GINIT,
		ST_GATH,
		ST_GWAIT,
		ST_SEL,
		ST_SWAIT,
		ST_SUPD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic store_wr;
		logic latch;
		logic mod_step;
		logic gath_init;
		logic gath_step;
		logic sel_init;
		logic sel_step;
		logic sel_upd;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic mod_last;
		logic gath_last;
		logic sel_last;
		logic bit_last;
		logic out_busy;
	} status_t;

endpackage

FILE: design/mfwb_if.sv
// ---------------------------------------------------------------------------
// mfwb_in_if / mfwb_out_if
// Valid/ready channels for requests and median results.
// ---------------------------------------------------------------------------
interface mfwb_in_if import mfwb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                command;
	logic [COORD_W-1:0]  row;
	logic [COORD_W-1:0]  col;
	logic [CHAN_W-1:0]   chan_a;
	logic [CHAN_W-1:0]   chan_b;
	logic [CHAN_W-1:0]   chan_c;

	modport source (output valid, command, row, col, chan_a, chan_b, chan_c, input ready);
	modport sink   (input valid, command, row, col, chan_a, chan_b, chan_c, output ready);
endinterface

interface mfwb_out_if import mfwb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CHAN_W-1:0]  median_a;
	logic [CHAN_W-1:0]  median_b;
	logic [CHAN_W-1:0]  median_c;

	modport source (output valid, median_a, median_b, median_c, input ready);
	modport sink   (input valid, median_a, median_b, median_c, output ready);
endinterface

FILE: design/mfwb_ram.sv
// ---------------------------------------------------------------------------
// mfwb_ram
// Single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module mfwb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write, and read the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/mfwb_ctrl.sv
// ---------------------------------------------------------------------------
// mfwb_ctrl
// Sequencer: modulo, window gather, bitwise rank select, result load.
// ---------------------------------------------------------------------------
module mfwb_ctrl import mfwb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_command,
	output logic    in_ready,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_command == CMD_QUERY) begin
						cmd.latch = 1'b1;
						state_d   = ST_MOD;
					end else begin
						cmd.store_wr = 1'b1;
					end
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) state_d = ST_GINIT;
			end
			ST_GINIT: begin
				cmd.gath_init = 1'b1;
				state_d       = ST_GATH;
			end
			ST_GATH: begin
				cmd.gath_step = 1'b1;
				if (sts.gath_last) state_d = ST_GWAIT;
			end
			ST_GWAIT: begin
				cmd.sel_init = 1'b1;
				state_d      = ST_SEL;
			end
			ST_SEL: begin
				cmd.sel_step = 1'b1;
				if (sts.sel_last) state_d = ST_SWAIT;
			end
			ST_SWAIT: begin
				state_d = ST_SUPD;
			end
			ST_SUPD: begin
				cmd.sel_upd = 1'b1;
				state_d     = sts.bit_last ? ST_DONE : ST_SEL;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: design/mfwb_dp.sv
// ---------------------------------------------------------------------------
// mfwb_dp
// Frame store, window buffer, wrap arithmetic and per-channel rank select.
// ---------------------------------------------------------------------------
module mfwb_dp import mfwb_pkg::*; #(
	parameter int WINDOW_RADIUS = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_idx,
	input  logic [SIZE_W-1:0]     cfg_data,
	input  logic [COORD_W-1:0]    in_row,
	input  logic [COORD_W-1:0]    in_col,
	input  logic [PIX_W-1:0]      in_pix,
	input  cmd_t                  cmd,
	output status_t               sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      out_pix
);

	localparam int SIDE = 2 * WINDOW_RADIUS + 1;
	localparam int NWIN = SIDE * SIDE;
	localparam int BW   = $clog2(NWIN);
	localparam int CNTW = $clog2(NWIN + 1);
	localparam int SW   = $clog2(SIDE);
	localparam logic [CNTW-1:0] RANK = CNTW'(NWIN / 2);

	logic [SIZE_W-1:0]  wreg_q, hreg_q, w_eff, h_eff;
	logic [COORD_W-1:0] crow_q, ccol_q;
	logic [COORD_W-1:0] rem_r_q, rem_c_q;
	logic [2:0]         mod_cnt_q;
	logic [SIZE_W-1:0]  tr, tc;
	logic [COORD_W-1:0] start_r, start_c;
	logic signed [10:0] sr, sc;
	logic [COORD_W-1:0] r_q, c_q, c0_q;
	logic [SW-1:0]      dr_q, dc_q;
	logic [BW-1:0]      bidx_q, bidx_s1;
	logic               rdv_s1;
	logic               wr_ok;
	logic [ADDR_W-1:0]  st_addr;
	logic [PIX_W-1:0]   st_rdata;
	logic [BW-1:0]      sa_q, buf_addr;
	logic [PIX_W-1:0]   buf_rdata;
	logic               selv_s1;
	logic [2:0]         bit_q;
	logic [CHAN_W-1:0]  mask;
	logic [CHAN_W-1:0]  pfx_q  [NCHAN];
	logic [CNTW-1:0]    rank_q [NCHAN];
	logic [CNTW-1:0]    cnt_q  [NCHAN];
	logic [NCHAN-1:0]   match;
	logic               out_valid_q;
	logic [PIX_W-1:0]   out_q;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wreg_q <= SIZE_RESET;
			hreg_q <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WIDTH:  wreg_q <= cfg_data;
				REG_HEIGHT: hreg_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// clamp sizes to the supported range
	assign w_eff = (wreg_q < MIN_SIZE) ? MIN_SIZE :
	               (wreg_q > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : wreg_q;
	assign h_eff = (hreg_q < MIN_SIZE) ? MIN_SIZE :
	               (hreg_q > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : hreg_q;

	// one restoring remainder step per cycle for row and column
	assign tr = {rem_r_q, crow_q[mod_cnt_q]};
	assign tc = {rem_c_q, ccol_q[mod_cnt_q]};

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			crow_q    <= in_row;
			ccol_q    <= in_col;
			rem_r_q   <= '0;
			rem_c_q   <= '0;
			mod_cnt_q <= 3'(COORD_W - 1);
		end else if (cmd.mod_step) begin
			rem_r_q   <= (tr >= h_eff) ? COORD_W'(tr - h_eff) : COORD_W'(tr);
			rem_c_q   <= (tc >= w_eff) ? COORD_W'(tc - w_eff) : COORD_W'(tc);
			mod_cnt_q <= mod_cnt_q - 3'd1;
		end
	end

	// window corner: centre remainder minus radius, wrapped back up
	always_comb begin
		sr = $signed({3'b000, rem_r_q}) - $signed(11'(WINDOW_RADIUS));
		sc = $signed({3'b000, rem_c_q}) - $signed(11'(WINDOW_RADIUS));
		if (sr < 0) sr = sr + $signed({2'b00, h_eff});
		if (sr < 0) sr = sr + $signed({2'b00, h_eff});
		if (sc < 0) sc = sc + $signed({2'b00, w_eff});
		if (sc < 0) sc = sc + $signed({2'b00, w_eff});
		start_r = sr[COORD_W-1:0];
		start_c = sc[COORD_W-1:0];
	end

	// walk the window row by row with wrapping coordinates
	always_ff @(posedge clk) begin
		if (cmd.gath_init) begin
			r_q    <= start_r;
			c_q    <= start_c;
			c0_q   <= start_c;
			dr_q   <= '0;
			dc_q   <= '0;
			bidx_q <= '0;
		end else if (cmd.gath_step) begin
			bidx_q <= bidx_q + 1'b1;
			if (dc_q == SW'(SIDE - 1)) begin
				dc_q <= '0;
				c_q  <= c0_q;
				dr_q <= dr_q + 1'b1;
				r_q  <= ({1'b0, r_q} == h_eff - 9'd1) ? '0 : r_q + 1'b1;
			end else begin
				dc_q <= dc_q + 1'b1;
				c_q  <= ({1'b0, c_q} == w_eff - 9'd1) ? '0 : c_q + 1'b1;
			end
		end
		bidx_s1 <= bidx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1  <= 1'b0;
			selv_s1 <= 1'b0;
		end else begin
			rdv_s1  <= cmd.gath_step;
			selv_s1 <= cmd.sel_step;
		end
	end

	// frame store: request writes inside the image, window reads otherwise
	assign wr_ok   = cmd.store_wr && ({1'b0, in_row} < h_eff) && ({1'b0, in_col} < w_eff);
	assign st_addr = cmd.store_wr ? {in_row, in_col} : {r_q, c_q};

	mfwb_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH * MAX_HEIGHT)
	) u_store (
		.clk   (clk),
		.we    (wr_ok),
		.addr  (st_addr),
		.wdata (in_pix),
		.rdata (st_rdata)
	);

	// window buffer: filled by the gather, then swept once per bit
	assign buf_addr = rdv_s1 ? bidx_s1 : sa_q;

	mfwb_ram #(
		.WIDTH (PIX_W),
		.DEPTH (NWIN)
	) u_win (
		.clk   (clk),
		.we    (rdv_s1),
		.addr  (buf_addr),
		.wdata (st_rdata),
		.rdata (buf_rdata)
	);

	// candidates agree with the prefix above the bit and have a zero there
	assign mask = ~(8'hFF >> (3'd7 - bit_q));

	always_comb begin
		for (int ch = 0; ch < NCHAN; ch++) begin
			match[ch] = (((buf_rdata[ch*CHAN_W +: CHAN_W] ^ pfx_q[ch]) & mask) == '0)
			            && !buf_rdata[ch*CHAN_W + int'(bit_q)];
		end
	end

	// radix select, most significant bit first
	always_ff @(posedge clk) begin
		if (cmd.sel_init) begin
			sa_q  <= '0;
			bit_q <= 3'(CHAN_W - 1);
			for (int ch = 0; ch < NCHAN; ch++) begin
				pfx_q[ch]  <= '0;
				rank_q[ch] <= RANK;
				cnt_q[ch]  <= '0;
			end
		end else begin
			if (cmd.sel_step) begin
				sa_q <= (sa_q == BW'(NWIN - 1)) ? '0 : sa_q + 1'b1;
			end
			if (selv_s1) begin
				for (int ch = 0; ch < NCHAN; ch++) begin
					cnt_q[ch] <= cnt_q[ch] + CNTW'(match[ch]);
				end
			end
			if (cmd.sel_upd) begin
				bit_q <= bit_q - 3'd1;
				for (int ch = 0; ch < NCHAN; ch++) begin
					cnt_q[ch] <= '0;
					if (rank_q[ch] >= cnt_q[ch]) begin
						pfx_q[ch][bit_q] <= 1'b1;
						rank_q[ch]       <= rank_q[ch] - cnt_q[ch];
					end
				end
			end
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= {pfx_q[2], pfx_q[1], pfx_q[0]};
		end
	end

	assign out_valid     = out_valid_q;
	assign out_pix       = out_q;
	assign sts.mod_last  = (mod_cnt_q == 3'd0);
	assign sts.gath_last = (dr_q == SW'(SIDE - 1)) && (dc_q == SW'(SIDE - 1));
	assign sts.sel_last  = (sa_q == BW'(NWIN - 1));
	assign sts.bit_last  = (bit_q == 3'd0);
	assign sts.out_busy  = out_valid_q;

endmodule

FILE: design/median_filter_wrap_border.sv
// ---------------------------------------------------------------------------
// median_filter_wrap_border
// Frame store of 3x8-bit pixels with per-channel median over a wrapped window.
//
// Channel   Dir  Carries
// in_ch     in   command, row, col, chan_a..chan_c
// out_ch    out  median_a..median_c, one per query
// cfg_*     in   image_width (index 0), image_height (index 1)
//
// A write is stored from the idle state. A query shows its result once the window of
// N = (2*WINDOW_RADIUS+1)^2 pixels is gathered and swept, and the next request is
// taken from then on; the wait is set by the single read port of the window
// buffer, swept once per result bit.
// Reset clears control and sets both size registers to 256; the frame store holds garbage until written.
// A finished result waits in the output register; requests are taken meanwhile.
// ---------------------------------------------------------------------------
module median_filter_wrap_border import mfwb_pkg::*; #(
	parameter int WINDOW_RADIUS = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mfwb_in_if.sink              in_ch,
	mfwb_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_idx,
	input  logic [SIZE_W-1:0]    cfg_data
);

	cmd_t             cmd;
	status_t          sts;
	logic             in_ready;
	logic [PIX_W-1:0] out_pix;

	mfwb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_command (in_ch.command),
		.in_ready   (in_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	mfwb_dp #(
		.WINDOW_RADIUS (WINDOW_RADIUS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_row    (in_ch.row),
		.in_col    (in_ch.col),
		.in_pix    ({in_ch.chan_c, in_ch.chan_b, in_ch.chan_a}),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_pix   (out_pix)
	);

	assign in_ch.ready     = in_ready;
	assign out_ch.median_a = out_pix[CHAN_W-1:0];
	assign out_ch.median_b = out_pix[2*CHAN_W-1:CHAN_W];
	assign out_ch.median_c = out_pix[3*CHAN_W-1:2*CHAN_W];

endmodule

FILE: design/mfwb_checker.sv
// ---------------------------------------------------------------------------
// mfwb_checker
// Port-level checks of the median filter, bound to the top level.
// ---------------------------------------------------------------------------
`include "median_filter_wrap_border_assert.svh"

module mfwb_checker import mfwb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              in_command,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAN_W-1:0] median_a,
	input logic [CHAN_W-1:0] median_b,
	input logic [CHAN_W-1:0] median_c
);

	// a stalled result holds
	`MFWB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(median_a) && $stable(median_b) && $stable(median_c))

	// a write request never makes a result
	`MFWB_ASSERT_NEXT(a_wr_no_result, clk, arst_n, in_valid && in_ready && (in_command == CMD_WRITE) && !out_valid, !out_valid)

	// a query request keeps the block busy
	`MFWB_ASSERT_NEXT(a_query_busy, clk, arst_n, in_valid && in_ready && (in_command == CMD_QUERY), !in_ready)

endmodule

bind median_filter_wrap_border mfwb_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_command (in_ch.command),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.median_a   (out_ch.median_a),
	.median_b   (out_ch.median_b),
	.median_c   (out_ch.median_c)
);
